// ----- sv/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Event codes, frame opcodes, header length escapes, limit reset value, mask size and result struct.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // event codes carried on the result channel
   localparam logic [2:0] EV_DATA       = 3'd0;
   localparam logic [2:0] EV_EMPTY_END  = 3'd1;
   localparam logic [2:0] EV_PING       = 3'd2;
   localparam logic [2:0] EV_PONG       = 3'd3;
   localparam logic [2:0] EV_CLOSE      = 3'd4;
   localparam logic [2:0] EV_UNMASKED   = 3'd5;
   localparam logic [2:0] EV_TOO_LARGE  = 3'd6;
   localparam logic [2:0] EV_BAD_OPCODE = 3'd7;

   // frame opcodes
   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   // 7-bit length escapes
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [31:0] MAX_SIZE_RESET = 32'd33554432;
   localparam int unsigned MASK_BYTES     = 4;

   typedef struct packed {
      logic       valid;
      logic [2:0] event_kind;
      logic [7:0] payload_byte;
      logic [3:0] message_opcode;
      logic       message_last;
   } wsd_result_type;

endpackage

// ----- sv/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser and unmasker
// Timing: an event is registered and appears on rsp in the cycle after its byte beat is accepted.
// Throughput: one byte beat per cycle; req_tready drops only while a held
//   event is not taken, since the single result register is the only buffer.
// Reset: synchronous; parser returns to the first header byte, no message is
//   open, the size limit reloads to 32 MiB and the result register empties.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // received stream, one byte per beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] payload_byte
   output logic [6:0]  rsp_tuser,   // [2:0] event_kind, [6:3] message_opcode
   output logic        rsp_tlast,   // message_last
   // message size limit register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // max_message_size
);
   import wsd_pkg::*;

   logic [31:0]    max_size_ff;
   logic           room;
   logic           beat_fire;
   wsd_result_type result;

   // the user must change the limit only while idle; the block does not enforce it and always takes the write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (csr_valid) begin
         max_size_ff <= csr_data;
      end
   end

   // a beat is taken whenever the result register is free or draining;
   // every beat, also one that raises no event, waits while a held event is stalled
   assign req_tready = room;
   assign beat_fire  = req_tvalid && req_tready;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat_fire (beat_fire),
      .rx_byte   (req_tdata),
      .max_size  (max_size_ff),
      .result    (result)
   );

   wsd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser: header parse, length tracking and payload unmask
// Holds the frame state; decodes one byte per beat into at most one event.
// ----------------------------------------------------------------------------
module wsd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat_fire,
   input  logic [7:0]              rx_byte,
   input  logic [31:0]             max_size,
   output wsd_pkg::wsd_result_type result
);
   import wsd_pkg::*;

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CLOSED  = 3'd6;

   localparam logic [2:0] MASK_LAST  = 3'(MASK_BYTES - 1);

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] rem_ff, rem_in;
   logic [2:0]  hbc_ff, hbc_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  midx_ff, midx_in;
   logic [31:0] msg_len_ff, msg_len_in;
   logic [3:0]  msg_op_ff, msg_op_in;

   logic        is_data;
   logic [63:0] len_new;
   logic        masked_now;
   logic [32:0] len_sum;
   logic        too_large;
   logic        len_done;
   logic [2:0]  final_idx;
   logic [7:0]  key_byte;
   logic [63:0] rem_dec;

   assign is_data    = (opcode_ff <= OP_BINARY);
   assign len_new    = (phase_ff == PH_HDR1) ? {57'd0, rx_byte[6:0]}
                                             : {rem_ff[55:0], rx_byte};
   assign masked_now = (phase_ff == PH_HDR1) ? rx_byte[7] : masked_ff;
   // upper half nonzero always overflows a 32-bit limit
   assign len_sum    = {1'b0, msg_len_ff} + {1'b0, len_new[31:0]};
   assign too_large  = (|len_new[63:32]) || (len_sum >= {1'b0, max_size});
   assign final_idx  = (phase_ff == PH_EXT16) ? 3'd1 : 3'd7;
   assign rem_dec    = rem_ff - 64'd1;

   always_comb begin
      case (midx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      masked_in  = masked_ff;
      rem_in     = rem_ff;
      hbc_in     = hbc_ff;
      key_in     = key_ff;
      midx_in    = midx_ff;
      msg_len_in = msg_len_ff;
      msg_op_in  = msg_op_ff;
      len_done   = 1'b0;
      result     = '0;

      case (phase_ff)
         PH_HDR0: begin
            fin_in    = rx_byte[7];
            opcode_in = rx_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            masked_in = rx_byte[7];
            rem_in    = '0;
            hbc_in    = '0;
            key_in    = '0;
            midx_in   = '0;
            if (is_data && !rx_byte[7]) begin
               result.valid      = 1'b1;
               result.event_kind = EV_UNMASKED;
               phase_in          = PH_CLOSED;
            end else if (opcode_ff == OP_CLOSE) begin
               result.valid      = 1'b1;
               result.event_kind = EV_CLOSE;
               phase_in          = PH_CLOSED;
            end else begin
               if (opcode_ff == OP_PING) begin
                  result.valid      = 1'b1;
                  result.event_kind = EV_PING;
               end else if (opcode_ff == OP_PONG) begin
                  result.valid      = 1'b1;
                  result.event_kind = EV_PONG;
               end else if (!is_data) begin
                  result.valid      = 1'b1;
                  result.event_kind = EV_BAD_OPCODE;
               end
               if (rx_byte[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  rem_in   = len_new;
                  len_done = 1'b1;
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            rem_in = len_new;
            if (hbc_ff >= final_idx) begin
               len_done = 1'b1;
            end else begin
               hbc_in = hbc_ff + 3'd1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            if (hbc_ff >= MASK_LAST) begin
               hbc_in  = '0;
               midx_in = '0;
               if (rem_ff != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_HDR0;
                  if (is_data && fin_ff) begin
                     result.valid          = 1'b1;
                     result.event_kind     = EV_EMPTY_END;
                     result.message_opcode = msg_op_ff;
                     result.message_last   = 1'b1;
                     msg_len_in            = '0;
                     msg_op_in             = OP_CONT;
                  end
               end
            end else begin
               hbc_in = hbc_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            if (is_data) begin
               result.valid          = 1'b1;
               result.event_kind     = EV_DATA;
               result.payload_byte   = rx_byte ^ key_byte;
               result.message_opcode = msg_op_ff;
               midx_in               = midx_ff + 2'd1;
               msg_len_in            = msg_len_ff + 32'd1;
            end
            if (rem_ff != '0) begin
               rem_in = rem_dec;
            end
            if (rem_ff <= 64'd1) begin
               phase_in = PH_HDR0;
               if (is_data && fin_ff) begin
                  result.message_last = 1'b1;
                  msg_len_in          = '0;
                  msg_op_in           = OP_CONT;
               end
            end
         end
         default: begin
            phase_in = PH_CLOSED;
         end
      endcase

      // frame length complete: limit check, message open, next phase
      if (len_done) begin
         hbc_in = '0;
         if (is_data && too_large) begin
            result.valid      = 1'b1;
            result.event_kind = EV_TOO_LARGE;
            phase_in          = PH_CLOSED;
         end else begin
            if (is_data && msg_op_ff == OP_CONT && opcode_ff != OP_CONT) begin
               msg_op_in = opcode_ff;
            end
            if (masked_now) begin
               phase_in = PH_MASK;
            end else if (len_new != '0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_HDR0;
            end
         end
      end

      result.valid = result.valid & beat_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opcode_ff  <= '0;
         masked_ff  <= 1'b0;
         rem_ff     <= '0;
         hbc_ff     <= '0;
         key_ff     <= '0;
         midx_ff    <= '0;
         msg_len_ff <= '0;
         msg_op_ff  <= OP_CONT;
      end else if (beat_fire) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         rem_ff     <= rem_in;
         hbc_ff     <= hbc_in;
         key_ff     <= key_in;
         midx_ff    <= midx_in;
         msg_len_ff <= msg_len_in;
         msg_op_ff  <= msg_op_in;
      end
   end

endmodule

// ----- sv/wsd_out_reg.sv -----
// ----------------------------------------------------------------------------
// wsd_out_reg: result register in front of the response channel
// Holds one event; refills in the same cycle the held event is taken.
// ----------------------------------------------------------------------------
module wsd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  wsd_pkg::wsd_result_type result,
   output logic                    room,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [6:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import wsd_pkg::*;

   logic       valid_ff;
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic [3:0] op_ff;
   logic       last_ff;

   assign room = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         kind_ff <= result.event_kind;
         byte_ff <= result.payload_byte;
         op_ff   <= result.message_opcode;
         last_ff <= result.message_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {op_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- sv/wsd_checker.sv -----
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks for the WebSocket frame deframer
// Event field consistency and result-channel stall behavior.
// ----------------------------------------------------------------------------
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [6:0] rsp_tuser,
   input logic       rsp_tlast
);
   import wsd_pkg::*;

   // held event must not change while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // input backpressure only comes from a stalled event
   a_ready_src: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled event");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != EV_DATA |-> rsp_tdata == 8'd0)
      else $error("payload byte set on a non-data event");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tuser[2:0] == EV_DATA || rsp_tuser[2:0] == EV_EMPTY_END)
      else $error("message end on a control or error event");

   a_op_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != EV_DATA && rsp_tuser[2:0] != EV_EMPTY_END
         |-> rsp_tuser[6:3] == OP_CONT)
      else $error("message opcode set on a control or error event");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
